// ===== rtl/assert_macros.svh =====
// assertion macros used by the decoder top level
// no dependencies; each macro takes a label, a property expression and a message, ASSERT_NEXT also a condition
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside of reset
`define ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// implication with the consequent checked in the cycle after the condition
`define ASSERT_NEXT(name, cond, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) else $error(msg);

`endif

// ===== rtl/bmmd_pkg.sv =====
// shared types and constants for the banked memory map decoder
// no dependencies; used by bmmd_stores and banked_memory_map_decoder
package bmmd_pkg;

   // fixed store sizes and default sizes of the loadable stores
   localparam int WORK_BYTES   = 65536;
   localparam int BACKUP_BYTES = 65536;
   localparam int ROM_BYTES_DEFAULT  = 8388608;
   localparam int BOOT_BYTES_DEFAULT = 131072;

   localparam int WORK_AW   = $clog2(WORK_BYTES);
   localparam int BACKUP_AW = $clog2(BACKUP_BYTES);
   localparam int ADDR_W    = 24;
   localparam int ROM_IDX_W = 24;
   localparam int BOOT_IDX_W = 17;

   // window bases on the bus, upper address bits
   localparam logic [3:0] WIN_ROM_FIXED = 4'h0;   // 0x000000-0x0FFFFF
   localparam logic [3:0] WIN_ROM_BANK  = 4'h2;   // 0x200000-0x2FFFFF
   localparam logic [7:0] WIN_WORK      = 8'h10;  // 0x100000-0x10FFFF
   localparam logic [7:0] WIN_SRAM      = 8'hD0;  // 0xD00000-0xD0FFFF
   localparam logic [6:0] WIN_BIOS      = 7'h60;  // 0xC00000-0xC1FFFF

   localparam logic [7:0] UNMAPPED_BYTE = 8'hFF;

   // item opcodes
   typedef enum logic [2:0] {
      OP_READ8      = 3'd0,
      OP_READ16     = 3'd1,
      OP_WRITE8     = 3'd2,
      OP_WRITE16    = 3'd3,
      OP_SET_BANK   = 3'd4,
      OP_LOAD_ROM   = 3'd5,
      OP_LOAD_BIOS  = 3'd6,
      OP_SOFT_RESET = 3'd7
   } opcode_type;

   // configuration register indexes
   localparam logic CSR_ROM_LEN  = 1'b0;
   localparam logic CSR_BIOS_LEN = 1'b1;

   // decoded region of one byte access
   typedef enum logic [2:0] {
      RG_NONE,
      RG_ROM,
      RG_WORK,
      RG_BIOS,
      RG_SRAM
   } region_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SECOND,
      ST_FINISH
   } state_type;

   // store access request of the current cycle
   typedef struct packed {
      logic                  rd_en;
      logic                  work_we;
      logic                  sram_we;
      logic                  rom_we;
      logic                  boot_we;
      logic [WORK_AW-1:0]    ram_idx;
      logic [ROM_IDX_W-1:0]  rom_idx;
      logic [BOOT_IDX_W-1:0] boot_idx;
      logic [7:0]            wdata;
   } mem_req_type;

   // registered read bytes of all stores
   typedef struct packed {
      logic [7:0] work_byte;
      logic [7:0] sram_byte;
      logic [7:0] rom_byte;
      logic [7:0] boot_byte;
   } mem_rsp_type;

endpackage

// ===== rtl/bmmd_stores.sv =====
// byte-wide stores of the decoder: work ram, sram, program rom and bios
// depends on bmmd_pkg; read data is registered and holds without a read
module bmmd_stores import bmmd_pkg::*; #(
   parameter int ROM_BYTES  = ROM_BYTES_DEFAULT,
   parameter int BOOT_BYTES = BOOT_BYTES_DEFAULT
) (
   input  logic        clock,
   input  mem_req_type mem_req,
   output mem_rsp_type mem_rsp
);

   localparam int ROM_AW  = $clog2(ROM_BYTES);
   localparam int BOOT_AW = $clog2(BOOT_BYTES);

   logic [7:0] work_mem [WORK_BYTES];
   logic [7:0] sram_mem [BACKUP_BYTES];
   logic [7:0] rom_mem  [ROM_BYTES];
   logic [7:0] boot_mem [BOOT_BYTES];

   logic [7:0] work_rd_ff;
   logic [7:0] sram_rd_ff;
   logic [7:0] rom_rd_ff;
   logic [7:0] boot_rd_ff;

   // work ram
   always_ff @(posedge clock) begin
      if (mem_req.work_we) begin
         work_mem[mem_req.ram_idx] <= mem_req.wdata;
      end
      if (mem_req.rd_en) begin
         work_rd_ff <= work_mem[mem_req.ram_idx];
      end
   end

   // backup sram
   always_ff @(posedge clock) begin
      if (mem_req.sram_we) begin
         sram_mem[mem_req.ram_idx[BACKUP_AW-1:0]] <= mem_req.wdata;
      end
      if (mem_req.rd_en) begin
         sram_rd_ff <= sram_mem[mem_req.ram_idx[BACKUP_AW-1:0]];
      end
   end

   // program rom
   always_ff @(posedge clock) begin
      if (mem_req.rom_we) begin
         rom_mem[mem_req.rom_idx[ROM_AW-1:0]] <= mem_req.wdata;
      end
      if (mem_req.rd_en) begin
         rom_rd_ff <= rom_mem[mem_req.rom_idx[ROM_AW-1:0]];
      end
   end

   // bios
   always_ff @(posedge clock) begin
      if (mem_req.boot_we) begin
         boot_mem[mem_req.boot_idx[BOOT_AW-1:0]] <= mem_req.wdata;
      end
      if (mem_req.rd_en) begin
         boot_rd_ff <= boot_mem[mem_req.boot_idx[BOOT_AW-1:0]];
      end
   end

   assign mem_rsp.work_byte = work_rd_ff;
   assign mem_rsp.sram_byte = sram_rd_ff;
   assign mem_rsp.rom_byte  = rom_rd_ff;
   assign mem_rsp.boot_byte = boot_rd_ff;

endmodule

// ===== rtl/banked_memory_map_decoder.sv =====
// top level of the banked memory map decoder: sequencer, address decode, csr
// depends on bmmd_pkg, bmmd_stores and assert_macros.svh
//
//   channel | direction | ports                                   | handshake
//   req     | in        | opcode, bus_address, write_data, bank   | valid/ready
//   rsp     | out       | read_data                               | valid/ready
//   csr     | in        | write, index, wdata                     | write strobe
//
// sequence: read8 passes through finish, read16 through second and finish, write16 through
// second; write8, set bank and loads stay idle (one store port, one byte per cycle, registered read data).
// reset: synchronous; a clearing pass zeroes every byte of work ram and sram,
// no item is accepted meanwhile; a soft reset runs the same pass on work ram.
// stalls: a finished read waits in its final cycle only while the output
// register still holds an item not yet taken.
`include "assert_macros.svh"

module banked_memory_map_decoder import bmmd_pkg::*; #(
   parameter int ROM_BYTES  = ROM_BYTES_DEFAULT,
   parameter int BOOT_BYTES = BOOT_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_opcode,
   input  logic [23:0] req_bus_address,
   input  logic [15:0] req_write_data,
   input  logic [7:0]  req_bank_number,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_read_data,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [23:0] csr_wdata
);

   localparam logic [27:0] ROM_LIMIT  = 28'(ROM_BYTES);
   localparam logic [24:0] ROM_LOAD_LIMIT = 25'(ROM_BYTES);
   localparam logic [24:0] BOOT_LIMIT = 25'(BOOT_BYTES);

   state_type   state_ff, state_in;
   opcode_type  op_ff, op_in;
   logic [23:0] addr_ff, addr_in;
   logic [7:0]  wlo_ff, wlo_in;
   logic [7:0]  hi_ff, hi_in;
   region_type  sel_ff, sel_in;
   logic        ok_ff, ok_in;
   logic [7:0]  bank_ff, bank_in;
   logic [23:0] rom_len_ff, rom_len_in;
   logic [17:0] bios_len_ff, bios_len_in;
   logic [WORK_AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic        clr_sram_ff, clr_sram_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_data_ff, rsp_data_in;

   logic        req_accept;
   logic        issue;
   opcode_type  cur_op;
   logic [23:0] cur_addr;
   region_type  cur_region;
   logic [27:0] rom_off;
   logic        rom_ok;
   logic        boot_ok;
   logic        cur_ok;
   logic        cur_read;
   logic        cur_write;
   logic [7:0]  byte_sel;
   logic        out_free;
   mem_req_type mem_req;
   mem_rsp_type mem_rsp;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // byte access of this cycle: first byte straight from the item, second at address+1
   always_comb begin
      issue    = req_accept || (state_ff == ST_SECOND);
      cur_op   = (state_ff == ST_IDLE) ? opcode_type'(req_opcode) : op_ff;
      cur_addr = (state_ff == ST_IDLE) ? req_bus_address : addr_ff + 24'd1;
      cur_read  = issue && (cur_op == OP_READ8 || cur_op == OP_READ16);
      cur_write = issue && (cur_op == OP_WRITE8 || cur_op == OP_WRITE16);
   end

   // window decode and loaded-size checks
   always_comb begin
      cur_region = RG_NONE;
      if (cur_addr[23:20] == WIN_ROM_FIXED || cur_addr[23:20] == WIN_ROM_BANK) begin
         cur_region = RG_ROM;
      end else if (cur_addr[23:16] == WIN_WORK) begin
         cur_region = RG_WORK;
      end else if (cur_addr[23:17] == WIN_BIOS) begin
         cur_region = RG_BIOS;
      end else if (cur_addr[23:16] == WIN_SRAM) begin
         cur_region = RG_SRAM;
      end
      rom_off = (cur_addr[23:20] == WIN_ROM_BANK) ? {bank_ff, cur_addr[19:0]}
                                                  : {8'd0, cur_addr[19:0]};
      rom_ok  = (rom_off < {4'd0, rom_len_ff}) && (rom_off < ROM_LIMIT);
      boot_ok = ({8'd0, cur_addr[16:0]} < {7'd0, bios_len_ff})
             && ({8'd0, cur_addr[16:0]} < BOOT_LIMIT);
      case (cur_region)
         RG_ROM:  cur_ok = rom_ok;
         RG_BIOS: cur_ok = boot_ok;
         RG_WORK: cur_ok = 1'b1;
         RG_SRAM: cur_ok = 1'b1;
         default: cur_ok = 1'b0;
      endcase
   end

   // store requests: clearing pass, byte reads and writes, loader writes
   always_comb begin
      mem_req.rd_en    = cur_read;
      mem_req.work_we  = 1'b0;
      mem_req.sram_we  = 1'b0;
      mem_req.rom_we   = 1'b0;
      mem_req.boot_we  = 1'b0;
      mem_req.ram_idx  = cur_addr[WORK_AW-1:0];
      mem_req.rom_idx  = rom_off[ROM_IDX_W-1:0];
      mem_req.boot_idx = cur_addr[BOOT_IDX_W-1:0];
      mem_req.wdata    = (state_ff == ST_SECOND) ? wlo_ff
                       : (cur_op == OP_WRITE16) ? req_write_data[15:8]
                       : req_write_data[7:0];
      if (state_ff == ST_CLEAR) begin
         mem_req.work_we = 1'b1;
         mem_req.sram_we = clr_sram_ff;
         mem_req.ram_idx = clr_cnt_ff;
         mem_req.wdata   = 8'd0;
      end else begin
         mem_req.work_we = cur_write && (cur_region == RG_WORK);
         mem_req.sram_we = cur_write && (cur_region == RG_SRAM);
         if (req_accept && cur_op == OP_LOAD_ROM) begin
            mem_req.rom_idx = cur_addr;
            mem_req.rom_we  = ({1'b0, cur_addr} < ROM_LOAD_LIMIT);
         end
         mem_req.boot_we = req_accept && (cur_op == OP_LOAD_BIOS)
                        && ({1'b0, cur_addr} < BOOT_LIMIT);
      end
   end

   bmmd_stores #(
      .ROM_BYTES  (ROM_BYTES),
      .BOOT_BYTES (BOOT_BYTES)
   ) u_stores (
      .clock   (clock),
      .mem_req (mem_req),
      .mem_rsp (mem_rsp)
   );

   // byte returned by the read issued in an earlier cycle
   always_comb begin
      case (sel_ff)
         RG_ROM:  byte_sel = mem_rsp.rom_byte;
         RG_WORK: byte_sel = mem_rsp.work_byte;
         RG_BIOS: byte_sel = mem_rsp.boot_byte;
         RG_SRAM: byte_sel = mem_rsp.sram_byte;
         default: byte_sel = UNMAPPED_BYTE;
      endcase
      if (!ok_ff) begin
         byte_sel = UNMAPPED_BYTE;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == {WORK_AW{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               case (cur_op)
                  OP_READ8:      state_in = ST_FINISH;
                  OP_READ16:     state_in = ST_SECOND;
                  OP_WRITE16:    state_in = ST_SECOND;
                  OP_SOFT_RESET: state_in = ST_CLEAR;
                  default:       state_in = ST_IDLE;
               endcase
            end
         end
         ST_SECOND: begin
            state_in = (op_ff == OP_READ16) ? ST_FINISH : ST_IDLE;
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and control register updates
   always_comb begin
      op_in        = op_ff;
      addr_in      = addr_ff;
      wlo_in       = wlo_ff;
      hi_in        = hi_ff;
      sel_in       = sel_ff;
      ok_in        = ok_ff;
      bank_in      = bank_ff;
      rom_len_in   = rom_len_ff;
      bios_len_in  = bios_len_ff;
      clr_cnt_in   = clr_cnt_ff;
      clr_sram_in  = clr_sram_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      if (req_accept) begin
         op_in   = cur_op;
         addr_in = req_bus_address;
         wlo_in  = req_write_data[7:0];
         if (cur_op == OP_SET_BANK) begin
            bank_in = req_bank_number;
         end else if (cur_op == OP_SOFT_RESET) begin
            bank_in = 8'd0;
         end
      end
      if (cur_read) begin
         sel_in = cur_region;
         ok_in  = cur_ok;
      end
      if (state_ff == ST_SECOND && op_ff == OP_READ16) begin
         hi_in = byte_sel;
      end
      if (state_ff == ST_FINISH && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = (op_ff == OP_READ16) ? {hi_ff, byte_sel} : {8'd0, byte_sel};
      end
      if (state_ff == ST_CLEAR) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == {WORK_AW{1'b1}}) begin
            clr_sram_in = 1'b0;
         end
      end
      if (csr_write) begin
         case (csr_index)
            CSR_ROM_LEN:  rom_len_in  = csr_wdata;
            CSR_BIOS_LEN: bios_len_in = csr_wdata[17:0];
            default:      rom_len_in  = rom_len_ff;
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         bank_ff      <= 8'd0;
         rom_len_ff   <= 24'd0;
         bios_len_ff  <= 18'd0;
         clr_cnt_ff   <= '0;
         clr_sram_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
         sel_ff       <= RG_NONE;
         ok_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bank_ff      <= bank_in;
         rom_len_ff   <= rom_len_in;
         bios_len_ff  <= bios_len_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_sram_ff  <= clr_sram_in;
         rsp_valid_ff <= rsp_valid_in;
         sel_ff       <= sel_in;
         ok_ff        <= ok_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      addr_ff     <= addr_in;
      wlo_ff      <= wlo_in;
      hi_ff       <= hi_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

   // checks
   `ASSERT_ALWAYS(a_clear_blocks_items, (state_ff != ST_CLEAR) || !req_ready,
      "item accepted during clearing pass")
   `ASSERT_ALWAYS(a_clear_count_idle, (state_ff == ST_CLEAR) || (clr_cnt_ff == '0),
      "clearing counter not at zero outside clearing pass")
   `ASSERT_NEXT(a_word_takes_second, req_accept && (req_opcode == OP_WRITE16 ||
      req_opcode == OP_READ16), state_ff == ST_SECOND, "16-bit access skipped second byte")
   `ASSERT_ALWAYS(a_no_write_during_read, !(mem_req.rd_en && (mem_req.work_we ||
      mem_req.sram_we)), "store read and write in the same cycle")

endmodule
